// File: rtl/core/sentence_boundary_tagger_macros.svh
// Assertion macros of the sentence boundary tagger RTL, used by sbt_core
`ifndef SENTENCE_BOUNDARY_TAGGER_MACROS_SVH
`define SENTENCE_BOUNDARY_TAGGER_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define SBT_ASSERT_INV(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sbt invariant violated");

// Consequence that must hold in the cycle after the antecedent
`define SBT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbt next-cycle check violated");

`endif

// File: rtl/core/sbt_pkg.sv
// Types, constants and helpers of the sentence boundary tagger
package sbt_pkg;

  localparam int unsigned IdxW = 16;
  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};
  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam int unsigned LenW = 3;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
  localparam logic [LenW-1:0] ShortTermLen = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CfgMinTokens = 2'd0;
  localparam logic [1:0] CfgMaxTokens = 2'd1;
  localparam logic [1:0] CfgStartTerm = 2'd2;

  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChBquot = 8'h60;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChSquot = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  typedef enum logic [1:0] {
    EcNone = 2'd0,
    EcStop = 2'd1,
    EcDot  = 2'd2
  } end_class_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       term_last;
    logic       doc_last;
  } sbt_item_t;

  // results of one character: a = pending period tag, b = term end tag,
  // c = remainder tag, d = sentence count
  typedef struct packed {
    logic [3:0]      mask;
    logic [15:0]     a_begin;
    logic [15:0]     a_end;
    logic [15:0]     b_begin;
    logic [15:0]     b_end;
    logic [15:0]     c_begin;
    logic [15:0]     c_end;
    logic [CntW-1:0] total;
  } sbt_bundle_t;

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {[ChUpA:ChUpZ]};
  endfunction

endpackage

// File: rtl/core/sbt_in_reg.sv
// Input register stage of the character stream
module sbt_in_reg import sbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbt_item_t in_item_i,
  input  logic      take_i,
  output logic      valid_o,
  output sbt_item_t item_o
);

  logic      valid_q;
  sbt_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: rtl/core/sbt_core.sv
// Per-character sentence boundary state, configuration registers and result build
`include "sentence_boundary_tagger_macros.svh"

module sbt_core import sbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        step_i,
  input  sbt_item_t   item_i,
  output sbt_bundle_t bundle_o
);

  logic [15:0]     min_q, max_q, start_q;
  logic [IdxW-1:0] ti_q, ti_d, ss_q, ss_d;
  logic [LenW-1:0] tlen_q, tlen_d;
  logic            fiu_q, fiu_d;
  end_class_e      ec_q, ec_d;
  logic            dot_q, dot_d, inner_q, inner_d, pend_q, pend_d;
  logic [CntW-1:0] kept_q, kept_d;

  function automatic logic keep(input logic [IdxW-1:0] b, input logic [IdxW-1:0] e,
                                input logic [15:0] lo, input logic [15:0] hi);
    logic [IdxW-1:0] len;
    len = e - b;
    return (IdxW'(lo) < len) && (len < IdxW'(hi));
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] k);
    return (k == CntMax) ? k : k + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= 16'hFFFF;
      start_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinTokens: min_q   <= cfg_data_i;
        CfgMaxTokens: max_q   <= cfg_data_i;
        CfgStartTerm: start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic            up, a_fire, a_keep, b_keep, c_keep, term_end;
    logic [IdxW-1:0] ss1, nxt;
    logic [CntW-1:0] k;
    up       = is_upper(item_i.ch);
    a_fire   = 1'b0;
    a_keep   = 1'b0;
    b_keep   = 1'b0;
    c_keep   = 1'b0;
    term_end = item_i.term_last || item_i.doc_last;
    ss1      = ss_q;
    k        = kept_q;
    pend_d   = pend_q;
    fiu_d    = fiu_q;

    // first character of a term settles a deferred period
    if (tlen_q == '0) begin
      if (pend_q) begin
        pend_d = 1'b0;
        if (up) begin
          a_fire = 1'b1;
          a_keep = keep(ss_q, ti_q, min_q, max_q);
          if (a_keep) k = sat_inc(k);
          ss1 = ti_q;
        end
      end
      fiu_d = up;
    end

    inner_d = inner_q || dot_q;
    dot_d   = dot_q || (item_i.ch == ChDot);
    tlen_d  = (tlen_q == LenMax) ? tlen_q : tlen_q + 1'b1;
    ec_d    = ec_q;
    if (!(item_i.ch inside {ChDquot, ChSquot, ChBquot, ChSpace, ChLt, ChGt})) begin
      if (item_i.ch inside {ChQuest, ChBang, ChSemi}) begin
        ec_d = EcStop;
      end else if (item_i.ch == ChDot) begin
        ec_d = EcDot;
      end else begin
        ec_d = EcNone;
      end
    end

    nxt  = (ti_q == IdxMax) ? ti_q : ti_q + 1'b1;
    ti_d = ti_q;
    ss_d = ss1;
    bundle_o.b_begin = ss1[15:0];
    bundle_o.b_end   = nxt[15:0];
    if (term_end) begin
      if (ec_d == EcStop) begin
        b_keep = keep(ss1, nxt, min_q, max_q);
        if (b_keep) k = sat_inc(k);
        ss_d = nxt;
      end else if (ec_d == EcDot) begin
        pend_d = !(fiu_d && (inner_d || tlen_d < ShortTermLen));
      end
      ti_d    = nxt;
      tlen_d  = '0;
      fiu_d   = 1'b0;
      ec_d    = EcNone;
      dot_d   = 1'b0;
      inner_d = 1'b0;
    end

    bundle_o.c_begin = ss_d[15:0];
    bundle_o.c_end   = ti_d[15:0];
    if (item_i.doc_last) begin
      if (ti_d > ss_d) begin
        c_keep = keep(ss_d, ti_d, min_q, max_q);
        if (c_keep) k = sat_inc(k);
      end
    end
    bundle_o.total = k;
    kept_d = k;

    if (item_i.doc_last) begin
      ti_d   = IdxW'(start_q);
      ss_d   = IdxW'(start_q);
      pend_d = 1'b0;
      kept_d = '0;
    end

    bundle_o.mask    = {item_i.doc_last, c_keep, b_keep, a_fire && a_keep};
    bundle_o.a_begin = ss_q[15:0];
    bundle_o.a_end   = ti_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ti_q    <= '0;
      ss_q    <= '0;
      tlen_q  <= '0;
      fiu_q   <= 1'b0;
      ec_q    <= EcNone;
      dot_q   <= 1'b0;
      inner_q <= 1'b0;
      pend_q  <= 1'b0;
      kept_q  <= '0;
    end else if (step_i) begin
      ti_q    <= ti_d;
      ss_q    <= ss_d;
      tlen_q  <= tlen_d;
      fiu_q   <= fiu_d;
      ec_q    <= ec_d;
      dot_q   <= dot_d;
      inner_q <= inner_d;
      pend_q  <= pend_d;
      kept_q  <= kept_d;
    end
  end

  `SBT_ASSERT_INV(a_start_le_index, clk_i, rst_ni, ss_q <= ti_q)
  // a deferred period only exists between terms
  `SBT_ASSERT_INV(a_pend_between_terms, clk_i, rst_ni, !pend_q || (tlen_q == '0))
  `SBT_ASSERT_NEXT(a_doc_end_clears, clk_i, rst_ni, step_i && item_i.doc_last,
                   (kept_q == '0) && (tlen_q == '0) && !pend_q && (ss_q == ti_q))

endmodule

// File: rtl/core/sbt_out_queue.sv
// Result register that holds one character's results and hands them out one by one
module sbt_out_queue import sbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  sbt_bundle_t bundle_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] tag_begin_o,
  output logic [15:0] tag_end_o,
  output logic [15:0] total_o,
  output logic        last_o
);

  sbt_bundle_t bundle_q;
  logic [3:0]  mask_q, mask_d, low, rest, remain;
  logic        pop;

  assign low         = mask_q & (~mask_q + 4'd1);
  assign rest        = mask_q & ~low;
  assign out_valid_o = |mask_q;
  assign pop         = out_valid_o && out_ready_i;
  assign remain      = pop ? rest : mask_q;
  assign take_o      = item_valid_i && (remain == 4'd0);
  assign mask_d      = take_o ? bundle_i.mask : remain;
  assign last_o      = (rest == 4'd0);

  always_comb begin
    kind_o      = 1'b0;
    tag_begin_o = '0;
    tag_end_o   = '0;
    total_o     = '0;
    case (1'b1)
      low[0]: begin
        tag_begin_o = bundle_q.a_begin;
        tag_end_o   = bundle_q.a_end;
      end
      low[1]: begin
        tag_begin_o = bundle_q.b_begin;
        tag_end_o   = bundle_q.b_end;
      end
      low[2]: begin
        tag_begin_o = bundle_q.c_begin;
        tag_end_o   = bundle_q.c_end;
      end
      low[3]: begin
        kind_o  = 1'b1;
        total_o = bundle_q.total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

// File: rtl/core/sentence_boundary_tagger.sv
// Top level of the sentence boundary tagger
// Path: a character is held in the input register, then its results in the result register,
//   from which they are handed out one by one.
// Throughput: one character per cycle while results are taken; a character with n > 1 results
//   holds the result register until all are taken, and the input waits meanwhile.
// Reset: asynchronous, active low; clears term and document state, empties both
//   registers and loads the configuration defaults (min 0, max 65535, start 0).
module sentence_boundary_tagger import sbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // term_last
  input  logic        s_axis_tuser_i,   // [0] doc_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] tag_begin, [31:16] tag_end,
                                        // [47:32] sentence_total
  output logic        m_axis_tlast_o,   // last
  output logic        m_axis_tuser_o,   // [0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  sbt_item_t   in_item, item;
  sbt_bundle_t bundle;
  logic        item_valid, take;
  logic [15:0] tag_begin, tag_end, total;

  assign in_item.ch        = s_axis_tdata_i;
  assign in_item.term_last = s_axis_tlast_i;
  assign in_item.doc_last  = s_axis_tuser_i;
  assign cfg_ready_o       = 1'b1;
  assign m_axis_tdata_o    = {total, tag_end, tag_begin};

  sbt_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  sbt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (take),
    .item_i      (item),
    .bundle_o    (bundle)
  );

  sbt_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .bundle_i     (bundle),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .kind_o       (m_axis_tuser_o),
    .tag_begin_o  (tag_begin),
    .tag_end_o    (tag_end),
    .total_o      (total),
    .last_o       (m_axis_tlast_o)
  );

endmodule

// File: bench/tb_sentence_boundary_tagger.sv
// Self-checking stream testbench of the sentence boundary tagger with a tag predictor
module tb_sentence_boundary_tagger;
  timeunit 1ns;
  timeprecision 1ps;
  import sbt_pkg::*;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic        kind;
    logic [15:0] tbeg;
    logic [15:0] tend;
    logic [15:0] total;
    logic        last;
  } tag_rec_t;

  localparam logic [7:0] LowA = "a";
  localparam logic [7:0] SkipChars [6] = '{ChDquot, ChSquot, ChBquot, ChSpace, ChLt, ChGt};
  localparam logic [1:0] RegOrder [3] = '{CfgMinTokens, CfgMaxTokens, CfgStartTerm};

  class tag_scoreboard;
    logic [15:0] min_tok;
    logic [15:0] max_tok;
    logic [15:0] start_idx;
    logic [15:0] term_idx;
    logic [15:0] sent_start;
    logic [15:0] kept;
    logic [2:0]  term_len;
    bit          first_up;
    bit          dot_seen;
    bit          inner_dot;
    bit          period_pend;
    end_class_e  cls;
    tag_rec_t    exp_q[$];
    tag_rec_t    batch[$];
    int          errors;

    function new();
      min_tok = '0;
      max_tok = '1;
      start_idx = '0;
      errors = 0;
      new_doc();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CfgMinTokens: min_tok = val;
        CfgMaxTokens: max_tok = val;
        CfgStartTerm: start_idx = val;
        default: ;
      endcase
    endfunction

    function void clear_term();
      term_len = '0;
      first_up = 1'b0;
      cls = EcNone;
      dot_seen = 1'b0;
      inner_dot = 1'b0;
    endfunction

    // start index only takes hold here, at a document boundary
    function void new_doc();
      term_idx = start_idx;
      sent_start = start_idx;
      period_pend = 1'b0;
      kept = '0;
      clear_term();
    endfunction

    function void put(logic kind, logic [15:0] b, logic [15:0] e, logic [15:0] tot);
      tag_rec_t r;
      r.kind = kind;
      r.tbeg = b;
      r.tend = e;
      r.total = tot;
      r.last = 1'b0;
      batch = {batch, r};
    endfunction

    function void try_tag(logic [15:0] b, logic [15:0] e);
      logic [15:0] len;
      len = e - b;
      if (min_tok < len && len < max_tok) begin
        put(1'b0, b, e, 16'd0);
        if (kept != CntMax) kept++;
      end
    endfunction

    function bit upper(logic [7:0] c);
      return c >= ChUpA && c <= ChUpZ;
    endfunction

    function void note_char(logic [7:0] c, logic tl, logic dl);
      logic [15:0] nxt;
      tag_rec_t r;
      batch.delete();
      // a deferred period is decided by the first character of the next term
      if (term_len == 0) begin
        if (period_pend) begin
          period_pend = 1'b0;
          if (upper(c)) begin
            try_tag(sent_start, term_idx);
            sent_start = term_idx;
          end
        end
        first_up = upper(c);
      end
      if (dot_seen) inner_dot = 1'b1;
      if (c == ChDot) dot_seen = 1'b1;
      if (term_len != LenMax) term_len++;
      if (!(c inside {ChDquot, ChSquot, ChBquot, ChSpace, ChLt, ChGt})) begin
        if (c inside {ChQuest, ChBang, ChSemi}) cls = EcStop;
        else if (c == ChDot) cls = EcDot;
        else cls = EcNone;
      end
      if (tl || dl) begin
        nxt = (term_idx != IdxMax) ? term_idx + 16'd1 : IdxMax;
        if (cls == EcStop) begin
          try_tag(sent_start, nxt);
          sent_start = nxt;
        end else if (cls == EcDot) begin
          period_pend = !(first_up && (inner_dot || term_len < ShortTermLen));
        end
        term_idx = nxt;
        clear_term();
      end
      if (dl) begin
        if (term_idx > sent_start) try_tag(sent_start, term_idx);
        put(1'b1, 16'd0, 16'd0, kept);
        new_doc();
      end
      if (batch.size() > 0) begin
        r = batch[batch.size()-1];
        r.last = 1'b1;
        batch[batch.size()-1] = r;
      end
      foreach (batch[i]) exp_q = {exp_q, batch[i]};
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [15:0] b, logic [15:0] e,
                               logic [15:0] tot, logic last);
      tag_rec_t w;
      if (exp_q.size() == 0) begin
        $error("result with none expected: kind %0d begin %0d end %0d total %0d",
               kind, b, e, tot);
        errors++;
        return;
      end
      w = exp_q.pop_front();
      cmp_field("kind", 16'(w.kind), 16'(kind));
      cmp_field("tag_begin", w.tbeg, b);
      cmp_field("tag_end", w.tend, e);
      cmp_field("sentence_total", w.total, tot);
      cmp_field("last", 16'(w.last), 16'(last));
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  tag_scoreboard sb;
  int send_odds;
  int recv_odds;
  int n_chars;
  bit hold_req;

  sentence_boundary_tagger u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("** sentence_boundary_tagger: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic tl, input logic dl);
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= tl;
    s_tuser <= dl;
    do @(posedge clk_i); while (!s_tready);
    sb.note_char(c, tl, dl);
    n_chars++;
  endtask

  task automatic send_term(input char_q_t t, input bit tl_end, input bit dl_end);
    foreach (t[i])
      push_char(t[i], tl_end && i == t.size() - 1, dl_end && i == t.size() - 1);
  endtask

  task automatic send_text(input string s, input bit tl_end, input bit dl_end);
    char_q_t t;
    for (int i = 0; i < s.len(); i++) t = {t, s[i]};
    send_term(t, tl_end, dl_end);
  endtask

  // hold the input until every tag is out and the pipeline has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] first);
    logic [15:0] vals [3];
    vals = '{lo, hi, first};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= RegOrder[i];
      cfg_data <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      sb.write_reg(RegOrder[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic char_q_t make_term();
    char_q_t t;
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 4)) t = {t, 8'($urandom)};
      return t;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) t = {t, 8'(ChUpA + $urandom_range(0, 25))};
    else if (pick < 85) t = {t, 8'(LowA + $urandom_range(0, 25))};
    else t = {t, 8'($urandom)};
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) t = {t, ChDot};
      else if (pick == 1) t = {t, 8'($urandom)};
      else t = {t, 8'(LowA + $urandom_range(0, 25))};
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) t = {t, ChDot};
    else if (pick < 40) t = {t, ChQuest};
    else if (pick < 45) t = {t, ChBang};
    else if (pick < 50) t = {t, ChSemi};
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) t = {t, SkipChars[$urandom_range(0, 5)]};
    return t;
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] first;
    int phase;
    int doc_left;
    char_q_t t;
    bit dl;
    sb = new();
    rst_ni <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgMinTokens;
    cfg_data <= '0;
    send_odds = 5;
    recv_odds = 5;
    hold_req = 1'b0;
    n_chars = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(16'd0, 16'hFFFF, 16'd0);
    send_text("Z;", 1'b1, 1'b0);
    send_text("x.", 1'b1, 1'b0);
    send_text("[", 1'b1, 1'b0);
    send_text("q.'", 1'b1, 1'b0);
    send_text("A!", 1'b1, 1'b0);
    // new start index written mid-document, used from the next one on
    settle();
    write_cfg(16'd0, 16'hFFFF, 16'd65533);
    send_text("U.S.", 1'b1, 1'b0);
    send_text("Ab.cd.", 1'b1, 1'b0);
    send_text("Abcde.", 1'b1, 1'b0);
    // pending period tag, remainder tag and count on one character
    send_text("B", 1'b1, 1'b1);
    // indices saturate; document closes on a period without a term end
    t = {8'h00};
    send_term(t, 1'b1, 1'b0);
    t = {8'hFF};
    send_term(t, 1'b1, 1'b0);
    send_text("c.", 1'b0, 1'b1);

    phase = 0;
    doc_left = 0;
    while (n_chars < 200) begin
      settle();
      case (phase % 6)
        0: begin lo = 16'd0; hi = 16'hFFFF; first = 16'd0; end
        1: begin
          lo = 16'($urandom_range(0, 2));
          hi = 16'($urandom_range(3, 8));
          first = 16'($urandom);
        end
        2: begin lo = 16'hFFFF; hi = 16'hFFFF; first = 16'(65535 - $urandom_range(0, 5)); end
        3: begin lo = 16'd0; hi = 16'd0; first = 16'($urandom); end
        4: begin lo = 16'($urandom); hi = 16'($urandom); first = 16'($urandom); end
        default: begin lo = 16'd0; hi = 16'($urandom_range(2, 6)); first = 16'd0; end
      endcase
      write_cfg(lo, hi, first);
      send_odds = pick_odds();
      recv_odds = pick_odds();
      if (phase == 0) hold_req = 1'b1;
      repeat ($urandom_range(6, 24)) begin
        if (doc_left == 0) doc_left = $urandom_range(1, 10);
        t = make_term();
        doc_left--;
        dl = (doc_left == 0);
        if (dl && $urandom_range(0, 7) == 0) send_term(t, 1'b0, 1'b1);
        else send_term(t, 1'b1, dl);
      end
      phase++;
    end

    // closing stretch at full speed on both sides
    send_odds = 0;
    recv_odds = 0;
    repeat (10) begin
      t = make_term();
      send_term(t, 1'b1, 1'b0);
    end
    t = make_term();
    send_term(t, 1'b1, 1'b1);
    settle();

    if (sb.errors == 0) begin
      $display("** sentence_boundary_tagger: PASSED **");
    end else begin
      $display("** sentence_boundary_tagger: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sbt_pkg.sv
rtl/core/sbt_in_reg.sv
rtl/core/sbt_core.sv
rtl/core/sbt_out_queue.sv
rtl/core/sentence_boundary_tagger.sv
bench/tb_sentence_boundary_tagger.sv
